// ===== hdl/descriptor_slot_allocator_core_defines.svh =====
// Assertion macros shared by the descriptor slot allocator RTL.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dsa_pkg.sv =====
// Shared types, codes and constants of the descriptor slot allocator.
`default_nettype none
package dsa_pkg;

  localparam int TABLE_DEPTH_DEF = 16384;

  localparam int IDX_W    = 14;
  localparam int CNT_W    = 15;
  localparam int STRIDE_W = 13;
  localparam int ADDR_W   = 48;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]    CAP_RESET    = 15'd16384;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;
  localparam logic [ADDR_W-1:0]   BASE_RESET   = 48'd0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd2;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_NONE_ACTIVE = 2'd2,
    ST_BAD         = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_ADDR = 2'd2
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot_index;
    logic [CNT_W-1:0]   active_slots;
    logic               addr_en;     // successful allocation: address is valid
  } result_t;

  typedef struct packed {
    logic in_ready;
    logic res_load;
    logic mul_en;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/dsa_stack_mem.sv =====
// Freed-slot LIFO storage: one write port, one registered read port.
`default_nettype none
module dsa_stack_mem #(
  parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [dsa_pkg::IDX_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [dsa_pkg::IDX_W-1:0] rd_data
);

  logic [dsa_pkg::IDX_W-1:0] mem [TABLE_DEPTH];
  logic [dsa_pkg::IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/dsa_addr_calc.sv =====
// Slot address: registered index * stride, then base add.
`default_nettype none
module dsa_addr_calc (
  input  wire logic                          clk,
  input  wire logic                          mul_en,
  input  wire logic [dsa_pkg::IDX_W-1:0]     idx,
  input  wire logic [dsa_pkg::STRIDE_W-1:0]  stride,
  input  wire logic [dsa_pkg::ADDR_W-1:0]    base,
  output logic      [dsa_pkg::ADDR_W-1:0]    addr
);

  localparam int PROD_W = dsa_pkg::IDX_W + dsa_pkg::STRIDE_W;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(idx) * PROD_W'(stride);
    end
  end

  // wraps modulo 2^48
  assign addr = base + dsa_pkg::ADDR_W'(prod_r);

endmodule
`default_nettype wire

// ===== hdl/dsa_ctrl.sv =====
// Sequencer and allocation bookkeeping around the freed-slot stack.
`default_nettype none
module dsa_ctrl #(
  parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_op,
  input  wire logic [dsa_pkg::IDX_W-1:0] in_index,
  input  wire logic                      out_space,
  input  wire logic [dsa_pkg::CNT_W-1:0] cap,
  output dsa_pkg::ctrl_t                 ctrl,
  output dsa_pkg::result_t               res,
  output logic      [dsa_pkg::IDX_W-1:0] mul_idx,
  output logic                           mem_rd_en,
  output logic      [AW-1:0]             mem_rd_addr,
  input  wire logic [dsa_pkg::IDX_W-1:0] mem_rd_data,
  output logic                           mem_wr_en,
  output logic      [AW-1:0]             mem_wr_addr,
  output logic      [dsa_pkg::IDX_W-1:0] mem_wr_data
);

  localparam int DW = AW + 1;

  dsa_pkg::state_t  state_r, state_nxt;
  logic                      op_r;
  logic [dsa_pkg::IDX_W-1:0] rel_r;
  logic [dsa_pkg::CNT_W-1:0] nf_r, nf_nxt;
  logic [DW-1:0]             depth_r, depth_nxt, depth_m1;
  logic [dsa_pkg::CNT_W-1:0] active_r, active_nxt;
  dsa_pkg::result_t          res_r, res_nxt;
  logic                      accept;
  logic                      exec;

  assign accept = in_valid && ctrl.in_ready;
  assign exec   = (state_r == dsa_pkg::S_EXEC);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = dsa_pkg::S_EXEC;
      end
      dsa_pkg::S_EXEC: state_nxt = dsa_pkg::S_ADDR;
      dsa_pkg::S_ADDR: begin
        if (out_space) state_nxt = in_valid ? dsa_pkg::S_EXEC : dsa_pkg::S_IDLE;
      end
      default: state_nxt = dsa_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      dsa_pkg::S_IDLE: ctrl.in_ready = 1'b1;
      dsa_pkg::S_EXEC: ctrl.mul_en = 1'b1;
      dsa_pkg::S_ADDR: begin
        ctrl.in_ready = out_space;
        ctrl.res_load = out_space;
      end
      default: ctrl = '0;
    endcase
  end

  // stack top is read at accept; the write of a free happens at the
  // end of EXEC, never on an accept edge, so no forwarding is needed
  assign depth_m1    = depth_r - DW'(1);
  assign mem_rd_en   = accept;
  assign mem_rd_addr = depth_m1[AW-1:0];
  assign mem_wr_addr = depth_r[AW-1:0];
  assign mem_wr_data = rel_r;

  always_comb begin
    nf_nxt     = nf_r;
    depth_nxt  = depth_r;
    active_nxt = active_r;
    res_nxt    = res_r;
    mem_wr_en  = 1'b0;
    if (exec) begin
      res_nxt = '{status: dsa_pkg::ST_OK, slot_index: '0,
                  active_slots: active_r, addr_en: 1'b0};
      if (op_r == dsa_pkg::OP_ALLOC) begin
        if (nf_r < cap) begin
          res_nxt.slot_index = nf_r[dsa_pkg::IDX_W-1:0];
          res_nxt.addr_en    = 1'b1;
          nf_nxt             = nf_r + dsa_pkg::CNT_W'(1);
        end else if (depth_r != '0) begin
          res_nxt.slot_index = mem_rd_data;
          res_nxt.addr_en    = 1'b1;
          depth_nxt          = depth_m1;
        end else begin
          res_nxt.status = dsa_pkg::ST_EMPTY;
        end
        if (res_nxt.addr_en && (active_r != '1)) begin
          active_nxt = active_r + dsa_pkg::CNT_W'(1);
        end
      end else begin
        if ({1'b0, rel_r} >= cap) begin
          res_nxt.status = dsa_pkg::ST_BAD;
        end else if (active_r == '0) begin
          res_nxt.status = dsa_pkg::ST_NONE_ACTIVE;
        end else if (depth_r == DW'(TABLE_DEPTH)) begin
          res_nxt.status = dsa_pkg::ST_BAD;
        end else begin
          mem_wr_en  = 1'b1;
          depth_nxt  = depth_r + DW'(1);
          active_nxt = active_r - dsa_pkg::CNT_W'(1);
        end
      end
      res_nxt.active_slots = active_nxt;
    end
  end

  assign mul_idx = res_nxt.slot_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dsa_pkg::S_IDLE;
      nf_r     <= '0;
      depth_r  <= '0;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      nf_r     <= nf_nxt;
      depth_r  <= depth_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      rel_r <= in_index;
    end
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hdl/descriptor_slot_allocator_core.sv =====
// Top level of the descriptor slot allocator: config, output stage, checks.
`default_nettype none
`include "descriptor_slot_allocator_core_defines.svh"
// Slot allocator for a fixed descriptor table. An allocate transaction
// (in_tuser = 0) hands out the next never-used slot until the capacity is
// used up, then pops the most recently freed slot from a LIFO stack held in
// a TABLE_DEPTH x 14 single-port-write RAM. A free transaction (in_tuser = 1)
// pushes in_tdata's index back. Errors (no slot left, free with none active,
// index at or above capacity, stack full) report a nonzero status and leave
// all state untouched. One transaction is in the bookkeeping at a time and
// the next is taken while the previous one's address is computed, as long
// as the output has space. The steps are the update state, which uses the
// stack word read on accept, and the address state; the index * stride
// product is registered and the 48-bit base add lands in the output
// register. A held output (out_tready low) stalls the pipeline one item
// deep. The stack needs no clearing after reset: only entries below the
// stack depth are ever used. Configuration writes are applied at once
// and must only happen while idle; slot_capacity is clamped to TABLE_DEPTH.
module descriptor_slot_allocator_core #(
  parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration: 0 slot_capacity, 1 slot_stride, 2 base_address
  input  wire logic                              cfg_we,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dsa_pkg::CFG_W-1:0]         cfg_wdata,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [15:0]                       in_tdata,  // [13:0] released_index
  input  wire logic [0:0]                        in_tuser,  // [0] op
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] status, [15:2] slot_index, [63:16] slot_address, [78:64] active_slots
  output logic      [79:0]                       out_tdata
);

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int CapMax   = (TABLE_DEPTH > 32767) ? 32767 : TABLE_DEPTH;
  localparam int CapReset = (TABLE_DEPTH < 16384) ? TABLE_DEPTH : 16384;

  logic [dsa_pkg::CNT_W-1:0]    cap_r;
  logic [dsa_pkg::STRIDE_W-1:0] stride_r;
  logic [dsa_pkg::ADDR_W-1:0]   base_r;

  dsa_pkg::ctrl_t               ctrl;
  dsa_pkg::result_t             res;
  logic [dsa_pkg::IDX_W-1:0]    mul_idx;
  logic                         mem_rd_en, mem_wr_en;
  logic [AW-1:0]                mem_rd_addr, mem_wr_addr;
  logic [dsa_pkg::IDX_W-1:0]    mem_rd_data, mem_wr_data;
  logic [dsa_pkg::ADDR_W-1:0]   calc_addr;
  logic                         out_space;

  logic                         out_valid_r;
  dsa_pkg::status_t             out_status_r;
  logic [dsa_pkg::IDX_W-1:0]    out_index_r;
  logic [dsa_pkg::ADDR_W-1:0]   out_addr_r;
  logic [dsa_pkg::CNT_W-1:0]    out_active_r;

  // Config registers; capacity is stored already clamped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= dsa_pkg::CNT_W'(CapReset);
      stride_r <= dsa_pkg::STRIDE_RESET;
      base_r   <= dsa_pkg::BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dsa_pkg::REG_CAPACITY: begin
          if (32'(cfg_wdata[dsa_pkg::CNT_W-1:0]) > 32'(CapMax)) begin
            cap_r <= dsa_pkg::CNT_W'(CapMax);
          end else begin
            cap_r <= cfg_wdata[dsa_pkg::CNT_W-1:0];
          end
        end
        dsa_pkg::REG_STRIDE: stride_r <= cfg_wdata[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::REG_BASE:   base_r   <= cfg_wdata[dsa_pkg::ADDR_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign out_space = !out_valid_r || out_tready;

  dsa_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_op       (in_tuser[0]),
    .in_index    (in_tdata[dsa_pkg::IDX_W-1:0]),
    .out_space   (out_space),
    .cap         (cap_r),
    .ctrl        (ctrl),
    .res         (res),
    .mul_idx     (mul_idx),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  dsa_stack_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  dsa_addr_calc u_addr (
    .clk    (clk),
    .mul_en (ctrl.mul_en),
    .idx    (mul_idx),
    .stride (stride_r),
    .base   (base_r),
    .addr   (calc_addr)
  );

  assign in_tready = ctrl.in_ready;

  // Output register: decouples the result from the next request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      out_status_r <= res.status;
      out_index_r  <= res.slot_index;
      out_addr_r   <= res.addr_en ? calc_addr : '0;
      out_active_r <= res.active_slots;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_active_r, out_addr_r, out_index_r, out_status_r};

  // One request in the bookkeeping at a time.
  `DSA_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready,
                   "request accepted in the cycle after an accept")
  // The stack read comes ahead of the result, which is never loaded straight after an accept.
  `DSA_ASSERT_NEXT(a_no_early_result, in_tvalid && in_tready, !ctrl.res_load,
                   "result loaded right after accept")
  // Read of the stack top and push never share a cycle.
  `DSA_ASSERT_NOW(a_mem_no_overlap, mem_wr_en, !mem_rd_en,
                  "stack read and write in the same cycle")
  // Failed requests carry neither an index nor an address; only error results are checked.
  `DSA_ASSERT_NOW(a_err_zero_payload,
                  out_valid_r && (out_status_r != dsa_pkg::ST_OK),
                  (out_index_r == '0) && (out_addr_r == '0),
                  "error result with nonzero index or address")

endmodule
`default_nettype wire

// ===== tb/slot_alloc_checker.sv =====
// Checker for the slot allocator: predicts each request's result and compares.
`timescale 1ns / 100ps
module slot_alloc_checker #(
  parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  output int          mismatch_total,
  output int          expected_left
);

  typedef struct packed {
    dsa_pkg::status_t                 status;
    logic [dsa_pkg::IDX_W-1:0]        slot_index;
    logic [dsa_pkg::ADDR_W-1:0]       slot_address;
    logic [dsa_pkg::CNT_W-1:0]        active_slots;
  } grant_t;

  logic [dsa_pkg::CNT_W-1:0]    capacity_reg;
  logic [dsa_pkg::STRIDE_W-1:0] stride_reg;
  logic [dsa_pkg::ADDR_W-1:0]   base_reg;

  int unsigned               fresh_next;
  int unsigned               stack_depth;
  int unsigned               held_count;
  logic [dsa_pkg::IDX_W-1:0] freed_slots [TABLE_DEPTH];
  grant_t                    grant_q [$];
  int                        err_count;

  // Work out the result of one request and update the shadow state.
  task automatic serve_request(input logic op, input logic [dsa_pkg::IDX_W-1:0] rel);
    grant_t      g;
    int unsigned eff_cap;
    int unsigned pick;
    bit          got;
    g.status       = dsa_pkg::ST_OK;
    g.slot_index   = '0;
    g.slot_address = '0;
    got            = 1'b0;
    pick           = 0;
    eff_cap = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : capacity_reg;
    if (op == dsa_pkg::OP_ALLOC) begin
      if (fresh_next < eff_cap) begin
        pick = fresh_next;
        fresh_next++;
        got = 1'b1;
      end else if (stack_depth > 0 && stack_depth <= TABLE_DEPTH) begin
        stack_depth--;
        pick = freed_slots[stack_depth];
        got = 1'b1;
      end else begin
        g.status = dsa_pkg::ST_EMPTY;
      end
      if (got) begin
        g.slot_index   = pick[dsa_pkg::IDX_W-1:0];
        g.slot_address = base_reg +
                         ({{(dsa_pkg::ADDR_W-dsa_pkg::IDX_W){1'b0}}, g.slot_index} *
                          {{(dsa_pkg::ADDR_W-dsa_pkg::STRIDE_W){1'b0}}, stride_reg});
        if (held_count < 32767) held_count++;
      end
    end else begin
      // index first, then none held, then stack full
      if (rel >= eff_cap) begin
        g.status = dsa_pkg::ST_BAD;
      end else if (held_count == 0) begin
        g.status = dsa_pkg::ST_NONE_ACTIVE;
      end else if (stack_depth >= TABLE_DEPTH) begin
        g.status = dsa_pkg::ST_BAD;
      end else begin
        freed_slots[stack_depth] = rel;
        stack_depth++;
        held_count--;
      end
    end
    g.active_slots = held_count[dsa_pkg::CNT_W-1:0];
    grant_q = {grant_q, g};
  endtask

  task automatic check_grant(input logic [79:0] word);
    grant_t want;
    if (grant_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: result with nothing outstanding: %h", $realtime, word);
    end else begin
      want = grant_q.pop_front();
      if (word[1:0] !== want.status || word[15:2] !== want.slot_index ||
          word[63:16] !== want.slot_address || word[78:64] !== want.active_slots) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: mismatch status %0d/%0d index %0d/%0d addr %h/%h active %0d/%0d",
                   $realtime, want.status, word[1:0], want.slot_index, word[15:2],
                   want.slot_address, word[63:16], want.active_slots, word[78:64]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity_reg = dsa_pkg::CAP_RESET;
      stride_reg   = dsa_pkg::STRIDE_RESET;
      base_reg     = dsa_pkg::BASE_RESET;
      fresh_next   = 0;
      stack_depth  = 0;
      held_count   = 0;
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dsa_pkg::REG_CAPACITY: capacity_reg = cfg_wdata[dsa_pkg::CNT_W-1:0];
          dsa_pkg::REG_STRIDE:   stride_reg   = cfg_wdata[dsa_pkg::STRIDE_W-1:0];
          dsa_pkg::REG_BASE:     base_reg     = cfg_wdata[dsa_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_grant(out_tdata);
      if (in_tvalid && in_tready) serve_request(in_tuser[0], in_tdata[dsa_pkg::IDX_W-1:0]);
    end
    mismatch_total <= err_count;
    expected_left  <= grant_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the slot allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = dsa_pkg::REG_CAPACITY;
  logic [47:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [15:0] in_tdata = '0;   // [13:0] released_index
  logic [0:0]  in_tuser = dsa_pkg::OP_ALLOC;   // [0] op
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  // [1:0] status, [15:2] slot_index, [63:16] slot_address, [78:64] active_slots
  wire  [79:0] out_tdata;

  int mismatch_total;
  int expected_left;

  // sender burst control; cap_hint steers free indices toward the live range
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int cap_hint = dsa_pkg::TABLE_DEPTH_DEF;

  // receiver stall pattern; rx_steady forces a no-stall stretch
  bit rx_steady = 1'b0;
  bit rx_hold = 1'b0;
  int rx_run = 0;

  always #5 clk = ~clk;

  descriptor_slot_allocator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  slot_alloc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_total (mismatch_total),
    .expected_left  (expected_left)
  );

  // Receiver: alternating ready runs and stalls, each of random length.
  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_hold = !rx_hold;
      rx_run  = rx_hold ? $urandom_range(1, 6) : $urandom_range(0, 24);
    end else begin
      rx_run--;
    end
    out_tready <= rx_steady || !rx_hold;
  end

  // One request transaction. valid stays up across back-to-back requests;
  // it only drops when a burst ends and a gap is inserted.
  task automatic send_req(input logic op, input logic [dsa_pkg::IDX_W-1:0] idx);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drain: wait for every outstanding result, then an idle margin.
  // The counts change at the rising edge, so they are read at the falling one.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Program all three registers, junk in the bits above each register's width.
  task automatic write_regs(input logic [dsa_pkg::CNT_W-1:0] cap,
                            input logic [dsa_pkg::STRIDE_W-1:0] stride,
                            input logic [dsa_pkg::ADDR_W-1:0] base);
    logic [47:0] junk;
    junk = 48'({$urandom, $urandom});
    cfg_we    <= 1'b1;
    cfg_index <= dsa_pkg::REG_CAPACITY;
    cfg_wdata <= {junk[47:dsa_pkg::CNT_W], cap};
    @(posedge clk);
    cfg_index <= dsa_pkg::REG_STRIDE;
    cfg_wdata <= {junk[47:dsa_pkg::STRIDE_W], stride};
    @(posedge clk);
    cfg_index <= dsa_pkg::REG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (cap == 0) cap_hint = 1;
    else if (cap > dsa_pkg::TABLE_DEPTH_DEF) cap_hint = dsa_pkg::TABLE_DEPTH_DEF;
    else cap_hint = cap;
  endtask

  // Mostly indices inside the capacity; some anywhere, some on the boundaries.
  function automatic logic [dsa_pkg::IDX_W-1:0] pick_index();
    int          r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 75) v = $urandom_range(0, cap_hint - 1);
    else if (r < 88) v = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = 16383;
        2:       v = cap_hint - 1;
        default: v = cap_hint;
      endcase
    end
    return v[dsa_pkg::IDX_W-1:0];
  endfunction

  task automatic random_traffic(input int count, input int alloc_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < alloc_pct) ? dsa_pkg::OP_ALLOC : dsa_pkg::OP_FREE;
      send_req(op, pick_index());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: frees with nothing held, then plain allocations, their frees and a double free
    send_req(dsa_pkg::OP_FREE, 14'd0);
    send_req(dsa_pkg::OP_FREE, 14'd16383);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'h3FFF);
    send_req(dsa_pkg::OP_FREE, 14'd1);
    send_req(dsa_pkg::OP_FREE, 14'd0);
    send_req(dsa_pkg::OP_FREE, 14'd0);
    settle();

    // Capacity 2: bad index wins over nothing held, exhaustion,
    // double free of the same slot
    write_regs(15'd2, 13'd1, 48'd0);
    send_req(dsa_pkg::OP_FREE, 14'd2);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_FREE, 14'd1);
    send_req(dsa_pkg::OP_FREE, 14'd1);
    settle();

    // Capacity above table depth is clamped; address wraps past 2^48
    write_regs(15'h7FFF, 13'h1FFF, 48'hFFFF_FFFF_FFFF);
    send_req(dsa_pkg::OP_FREE, 14'd16383);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    settle();

    // Capacity zero: every free is out of range, allocation only from stack
    write_regs(15'd0, 13'd4096, 48'({$urandom, $urandom}));
    send_req(dsa_pkg::OP_FREE, 14'd0);
    send_req(dsa_pkg::OP_ALLOC, 14'd0);
    settle();

    // Random phases, each with its own register setting; pacing varies between them
    gaps_on = 1'b1;
    write_regs(15'h7FFF, 13'h1FFF, 48'({$urandom, $urandom}));
    random_traffic(450, 60);
    settle();

    // capacity far below the fresh pointer: all traffic through the stack
    gaps_on   = 1'b0;
    rx_steady = 1'b1;
    write_regs(15'd16, 13'd1, 48'hFFFF_FFFF_FFFF);
    random_traffic(300, 45);
    settle();

    gaps_on   = 1'b1;
    rx_steady = 1'b0;
    write_regs(15'd1, 13'd4096, 48'({$urandom, $urandom}));
    random_traffic(200, 50);
    settle();

    write_regs(15'd16384, 13'($urandom_range(1, 8191)), 48'd0);
    random_traffic(550, 55);
    settle();

    if (mismatch_total == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dsa_pkg.sv
hdl/dsa_stack_mem.sv
hdl/dsa_addr_calc.sv
hdl/dsa_ctrl.sv
hdl/descriptor_slot_allocator_core.sv
tb/slot_alloc_checker.sv
tb/tb_top.sv
